// ===== design/nsc_pkg.sv =====
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared types, register indexes and class codes for the neighbor-sum
// compare stencil.
// ----------------------------------------------------------------------------
package nsc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 18;
  localparam int ROW_W    = 16;
  localparam int CFG_W    = 16;

  // configuration register indexes
  localparam logic [0:0] CFG_COLUMNS = 1'b0;
  localparam logic [0:0] CFG_ROWS    = 1'b1;

  localparam logic [6:0]       COLUMNS_RESET = 7'd5;
  localparam logic [ROW_W-1:0] ROWS_RESET    = 16'd5;

  // cell class codes
  localparam logic [1:0] CLASS_LESS    = 2'd0;
  localparam logic [1:0] CLASS_EQUAL   = 2'd1;
  localparam logic [1:0] CLASS_GREATER = 2'd2;

  // neighborhood of the cell at the head of the pipe
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;    // cell (r,c)
    logic signed [SAMPLE_W-1:0] up;        // (r-1,c)
    logic signed [SAMPLE_W-1:0] up_left;   // (r-1,c-1)
    logic signed [SAMPLE_W-1:0] up_right;  // (r-1,c+1)
    logic signed [SAMPLE_W-1:0] up_up;     // (r-2,c)
    logic signed [SAMPLE_W-1:0] left1;     // (r,c-1)
    logic signed [SAMPLE_W-1:0] left2;     // (r,c-2)
    logic                       has_up;
    logic                       has_up2;
    logic                       has_left;
    logic                       has_left2;
    logic                       has_right;
  } window_t;

  function automatic logic [1:0] classify(logic signed [SUM_W-1:0] center,
                                          logic signed [SUM_W-1:0] sum);
    logic [1:0] cls;
    if (center > sum) begin
      cls = CLASS_GREATER;
    end else if (center == sum) begin
      cls = CLASS_EQUAL;
    end else begin
      cls = CLASS_LESS;
    end
    return cls;
  endfunction

endpackage

// ===== design/nsc_ram.sv =====
// ----------------------------------------------------------------------------
// nsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/nsc_eval.sv =====
// ----------------------------------------------------------------------------
// nsc_eval
// Neighbor sums and classification for the three results one sample can
// complete: the cell above, the cell to the left (last row) and the cell
// itself (last cell of the grid).
// ----------------------------------------------------------------------------
module nsc_eval (
  input  nsc_pkg::window_t win_i,
  output logic [1:0]       cls_up_o,
  output logic [1:0]       cls_left_o,
  output logic [1:0]       cls_self_o
);

  logic signed [nsc_pkg::SUM_W-1:0] v_s, up_s, ul_s, ur_s, uu_s, l1_s, l2_s;
  logic signed [nsc_pkg::SUM_W-1:0] sum_up, sum_left, sum_self;

  always_comb begin
    v_s  = nsc_pkg::SUM_W'(win_i.sample);
    up_s = nsc_pkg::SUM_W'(win_i.up);
    ul_s = win_i.has_left  ? nsc_pkg::SUM_W'(win_i.up_left)  : '0;
    ur_s = win_i.has_right ? nsc_pkg::SUM_W'(win_i.up_right) : '0;
    uu_s = win_i.has_up2   ? nsc_pkg::SUM_W'(win_i.up_up)    : '0;
    l1_s = nsc_pkg::SUM_W'(win_i.left1);
    l2_s = win_i.has_left2 ? nsc_pkg::SUM_W'(win_i.left2)    : '0;

    sum_up   = v_s + uu_s + ul_s + ur_s;
    sum_left = v_s + (win_i.has_up ? ul_s : '0) + l2_s;
    sum_self = (win_i.has_up ? up_s : '0) + (win_i.has_left ? l1_s : '0);

    cls_up_o   = nsc_pkg::classify(up_s, sum_up);
    cls_left_o = nsc_pkg::classify(l1_s, sum_left);
    cls_self_o = nsc_pkg::classify(v_s, sum_self);
  end

endmodule

// ===== design/neighbor_sum_compare_stencil_core.sv =====
// ----------------------------------------------------------------------------
// neighbor_sum_compare_stencil_core
// Classifies each cell of a raster-ordered grid against the sum of its
// in-grid up, down, left and right neighbors.
// ----------------------------------------------------------------------------
// Samples enter in raster order, one request per cycle while ready. Each
// accepted sample is registered together with line-buffer reads of the row
// above and the row two above, classified in the next cycle, and the results
// leave through an output register one per cycle unless the output stalls.
// A sample outside the last row completes at most one result (the cell above
// it), so the block sustains one sample per cycle there unless the output
// stalls; on the last row a sample past column 0 completes up to two results
// and the final sample up to three, which the single output register sends
// one at a time while the input waits. Writing either configuration register
// restarts the grid at row 0, column 0; the line buffers need no clearing.
module neighbor_sum_compare_stencil_core #(
  parameter int MAX_COLUMNS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [0:0]                         cfg_index_i,
  input  logic [nsc_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [nsc_pkg::SAMPLE_W-1:0] sample_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         cell_class_o,
  output logic [nsc_pkg::ROW_W-1:0]          row_index_o,
  output logic [5:0]                         column_index_o,
  output logic                               last_of_run_o,
  output logic                               grid_done_o
);

  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  // configuration
  logic [6:0]                  cols_q;
  logic [nsc_pkg::ROW_W-1:0]   rows_q;
  logic [CW:0]                 eff_cols;
  logic [CW:0]                 last_col_w;
  logic [CW-1:0]               last_col;
  logic [nsc_pkg::ROW_W-1:0]   last_row_idx;

  // position of the next sample
  logic [CW-1:0]               col_q;
  logic [nsc_pkg::ROW_W-1:0]   row_q;
  logic                        at_last_col, at_last_row;

  // handshake
  logic                        accept, emit, retire, out_free;

  // stage 1
  logic                        s1_valid_q;
  logic [2:0]                  pend_q, pend_low, pend_rest, pend_d;
  logic signed [nsc_pkg::SAMPLE_W-1:0] s1_v_q;
  logic [nsc_pkg::ROW_W-1:0]   s1_row_q;
  logic [CW-1:0]               s1_col_q;
  logic                        s1_has_up_q, s1_has_up2_q, s1_has_left_q;
  logic                        s1_has_left2_q, s1_has_right_q;
  logic                        hit_c_q, hit_n_q;
  logic signed [nsc_pkg::SAMPLE_W-1:0] byp_v_q, byp_up_q;
  logic signed [nsc_pkg::SAMPLE_W-1:0] ul_q, l1_q, l2_q;

  // line buffers
  logic [CW-1:0]               raddr_next;
  logic [nsc_pkg::SAMPLE_W-1:0] ram_up, ram_ur, ram_uu;
  logic signed [nsc_pkg::SAMPLE_W-1:0] up_sel, ur_sel, uu_sel;

  nsc_pkg::window_t            win;
  logic [1:0]                  cls_up, cls_left, cls_self;

  // output register
  logic                        out_valid_q;
  logic [1:0]                  out_cls_q;
  logic [nsc_pkg::ROW_W-1:0]   out_row_q;
  logic [CW-1:0]               out_col_q;
  logic                        out_last_q, out_done_q;
  logic [CW+5:0]               out_col_wide;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= nsc_pkg::COLUMNS_RESET;
      rows_q <= nsc_pkg::ROWS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        nsc_pkg::CFG_COLUMNS: cols_q <= cfg_data_i[6:0];
        nsc_pkg::CFG_ROWS:    rows_q <= cfg_data_i;
      endcase
    end
  end

  always_comb begin
    if (cols_q == '0) begin
      eff_cols = (CW+1)'(1);
    end else if (32'(cols_q) > MAX_COLUMNS) begin
      eff_cols = (CW+1)'(MAX_COLUMNS);
    end else begin
      eff_cols = (CW+1)'(cols_q);
    end
    last_col_w   = eff_cols - (CW+1)'(1);
    last_col     = last_col_w[CW-1:0];
    last_row_idx = (rows_q == '0) ? '0 : rows_q - nsc_pkg::ROW_W'(1);
  end

  assign at_last_col = (col_q == last_col);
  assign at_last_row = (row_q >= last_row_idx);

  // --------------------------------------------------------------------------
  // handshake and result sequencing
  // --------------------------------------------------------------------------
  assign pend_low   = pend_q & (~pend_q + 3'd1);
  assign pend_rest  = pend_q & ~pend_low;
  assign out_free   = !out_valid_q || out_ready_i;
  assign emit       = s1_valid_q && (pend_q != '0) && out_free;
  assign retire     = s1_valid_q && (pend_rest == '0) && ((pend_q == '0) || out_free);
  assign in_ready_o = !s1_valid_q || retire;
  assign accept     = in_valid_i && in_ready_o;

  // results completed by the sample at (row_q, col_q)
  assign pend_d = {at_last_row && at_last_col,
                   at_last_row && (col_q != '0),
                   row_q != '0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_we_i) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (!at_last_col) begin
        col_q <= col_q + CW'(1);
      end else if (at_last_row) begin
        col_q <= '0;
        row_q <= '0;
      end else begin
        col_q <= '0;
        row_q <= row_q + nsc_pkg::ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      pend_q     <= '0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
      pend_q     <= pend_d;
    end else begin
      if (retire) begin
        s1_valid_q <= 1'b0;
      end
      if (emit) begin
        pend_q <= pend_rest;
      end
    end
  end

  // stage 1 payload; the bypass covers a read at the address being written
  // by the sample that leaves in the same cycle
  assign raddr_next = col_q + CW'(1);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_v_q         <= sample_value_i;
      s1_row_q       <= row_q;
      s1_col_q       <= col_q;
      s1_has_up_q    <= (row_q != '0);
      s1_has_up2_q   <= (row_q > nsc_pkg::ROW_W'(1));
      s1_has_left_q  <= (col_q != '0);
      s1_has_left2_q <= (col_q > CW'(1));
      s1_has_right_q <= !at_last_col;
      hit_c_q        <= retire && (s1_col_q == col_q);
      hit_n_q        <= retire && (s1_col_q == raddr_next);
      byp_v_q        <= s1_v_q;
      byp_up_q       <= up_sel;
    end
    if (retire) begin
      ul_q <= up_sel;
      l1_q <= s1_v_q;
      l2_q <= l1_q;
    end
  end

  // --------------------------------------------------------------------------
  // line buffers: two copies of the row above, one of the row two above
  // --------------------------------------------------------------------------
  nsc_ram #(.WIDTH(nsc_pkg::SAMPLE_W), .DEPTH(MAX_COLUMNS)) u_row1_c (
    .clk_i   (clk_i),
    .we_i    (retire),
    .waddr_i (s1_col_q),
    .wdata_i (s1_v_q),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (ram_up)
  );

  nsc_ram #(.WIDTH(nsc_pkg::SAMPLE_W), .DEPTH(MAX_COLUMNS)) u_row1_n (
    .clk_i   (clk_i),
    .we_i    (retire),
    .waddr_i (s1_col_q),
    .wdata_i (s1_v_q),
    .re_i    (accept),
    .raddr_i (raddr_next),
    .rdata_o (ram_ur)
  );

  nsc_ram #(.WIDTH(nsc_pkg::SAMPLE_W), .DEPTH(MAX_COLUMNS)) u_row2 (
    .clk_i   (clk_i),
    .we_i    (retire),
    .waddr_i (s1_col_q),
    .wdata_i (up_sel),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (ram_uu)
  );

  assign up_sel = hit_c_q ? byp_v_q  : ram_up;
  assign ur_sel = hit_n_q ? byp_v_q  : ram_ur;
  assign uu_sel = hit_c_q ? byp_up_q : ram_uu;

  // --------------------------------------------------------------------------
  // classification
  // --------------------------------------------------------------------------
  always_comb begin
    win.sample    = s1_v_q;
    win.up        = up_sel;
    win.up_left   = ul_q;
    win.up_right  = ur_sel;
    win.up_up     = uu_sel;
    win.left1     = l1_q;
    win.left2     = l2_q;
    win.has_up    = s1_has_up_q;
    win.has_up2   = s1_has_up2_q;
    win.has_left  = s1_has_left_q;
    win.has_left2 = s1_has_left2_q;
    win.has_right = s1_has_right_q;
  end

  nsc_eval u_eval (
    .win_i      (win),
    .cls_up_o   (cls_up),
    .cls_left_o (cls_left),
    .cls_self_o (cls_self)
  );

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_last_q <= (pend_rest == '0);
      out_done_q <= pend_low[2];
      priority if (pend_low[0]) begin
        out_cls_q <= cls_up;
        out_row_q <= s1_row_q - nsc_pkg::ROW_W'(1);
        out_col_q <= s1_col_q;
      end else if (pend_low[1]) begin
        out_cls_q <= cls_left;
        out_row_q <= s1_row_q;
        out_col_q <= s1_col_q - CW'(1);
      end else begin
        out_cls_q <= cls_self;
        out_row_q <= s1_row_q;
        out_col_q <= s1_col_q;
      end
    end
  end

  assign out_col_wide   = (CW+6)'(out_col_q);
  assign out_valid_o    = out_valid_q;
  assign cell_class_o   = out_cls_q;
  assign row_index_o    = out_row_q;
  assign column_index_o = out_col_wide[5:0];
  assign last_of_run_o  = out_last_q;
  assign grid_done_o    = out_done_q;

endmodule
